>>> sv/xsd_pkg.sv
// Shared types, codes and constants for the xorshift32 dice generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package xsd_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic [31:0] SEED_FALLBACK = 32'h1D2D1D2D;

  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_RANGE = 2'd2,
    OP_DICE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic in_dice_empty;
    logic dice;
    logic last_roll;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> sv/xorshift32_dice_generator.sv
// xorshift32 dice generator: 32-bit xorshift state (shifts 13, 17, 5) serving word, byte,
// range and dice requests. One item is taken at a time. Word, byte and range requests take
// one generator step in the run state, then load their result in the done state. A dice
// request steps count times, since the single xorshift/scale unit rolls one die per cycle;
// a count of zero goes straight to the done state. A held result keeps the done state
// waiting, so the next result is loaded only once the output is free. The result sits in
// an output register, so the next item is accepted while it waits. The seed register
// (APB, address 0) loads the state; a zero seed loads 0x1D2D1D2D, the reset state.
// Depends on xsd_pkg, xsd_step and xsd_seq.
`timescale 1ns / 1ps
`default_nettype none
module xorshift32_dice_generator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [23:0]                s_tdata,  // operation[1:0], bound[9:2], count[17:10]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [47:0]                m_tdata,  // value[15:0], state_after[47:16]
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [xsd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import xsd_pkg::*;

  logic [31:0] seed;
  logic [31:0] gen_state;
  op_t         op;
  logic [7:0]  bound;
  logic [7:0]  remain;
  logic [7:0]  acc;
  logic [15:0] res;
  logic [31:0] step_state;
  logic [7:0]  scaled;
  op_t         in_op;
  logic        cfg_write;
  status_t     status;
  ctl_t        ctl;

  assign in_op     = op_t'(s_tdata[1:0]);
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : seed;

  assign status.in_dice_empty = (in_op == OP_DICE) && (s_tdata[17:10] == 8'd0);
  assign status.dice          = (op == OP_DICE);
  assign status.last_roll     = (remain == 8'd1);
  assign status.out_free      = !m_tvalid || m_tready;

  xsd_step u_step (
    .state_in  (gen_state),
    .bound     (bound),
    .state_out (step_state),
    .scaled    (scaled)
  );

  xsd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .in_ready (s_tready),
    .ctl      (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= 32'd0;
      gen_state <= SEED_FALLBACK;
    end else if (cfg_write) begin
      seed      <= pwdata;
      gen_state <= (pwdata == 32'd0) ? SEED_FALLBACK : pwdata;
    end else if (ctl.step) begin
      gen_state <= step_state;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op     <= in_op;
      bound  <= s_tdata[9:2];
      remain <= s_tdata[17:10];
      acc    <= 8'd0;
      res    <= 16'd0;
    end else if (ctl.step) begin
      remain <= remain - 8'd1;
      acc    <= acc + 8'd1 + scaled;
      unique case (op)
        OP_WORD:  res <= step_state[31:16];
        OP_BYTE:  res <= {8'd0, step_state[31:24]};
        OP_RANGE: res <= {8'd0, scaled};
        OP_DICE:  res <= 16'd0;
        default:  res <= 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      m_tdata <= {gen_state, (op == OP_DICE) ? {8'd0, acc} : res};
    end
  end

endmodule
`default_nettype wire

>>> sv/xsd_step.sv
// Shared generator unit: one xorshift step and the byte scaled by a bound.
// Depends on xsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xsd_step (
  input  wire logic [31:0] state_in,
  input  wire logic [7:0]  bound,
  output logic      [31:0] state_out,
  output logic      [7:0]  scaled
);
  import xsd_pkg::*;

  logic [31:0] x1;
  logic [31:0] x2;
  logic [15:0] prod;

  always_comb begin
    x1        = state_in ^ (state_in << 13);
    x2        = x1 ^ (x1 >> 17);
    state_out = x2 ^ (x2 << 5);
    prod      = 16'(state_out[31:24]) * 16'(bound);
    scaled    = prod[15:8];
  end

endmodule
`default_nettype wire

>>> sv/xsd_seq.sv
// Sequencer for the dice generator: accepts an item, steps the shared unit, hands off the result.
// Depends on xsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xsd_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire xsd_pkg::status_t status,
  output logic                  in_ready,
  output xsd_pkg::ctl_t         ctl
);
  import xsd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_dice_empty ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.dice || status.last_roll) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_RUN: begin
        ctl.step = 1'b1;
      end
      ST_DONE: begin
        ctl.finish = status.out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for xorshift32_dice_generator: random-paced stream traffic,
// seed writes over APB, and an in-bench xorshift predictor compared field by field.
// Depends on xsd_pkg and the xorshift32_dice_generator RTL.
`timescale 1ns / 1ps
module tb;
  import xsd_pkg::*;

  localparam int REG_SEED  = 0;
  localparam int REG_SPARE = 1;  // lies beyond the register map

  typedef struct {
    op_t        op;
    logic [7:0] bound;
    logic [7:0] count;
  } dice_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic [31:0] state;
  } dice_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  wire logic          s_tready;
  logic [23:0]        s_tdata = '0;   // operation[1:0], bound[9:2], count[17:10]
  wire logic          m_tvalid;
  logic               m_tready = 1'b0;
  wire logic [47:0]   m_tdata;        // value[15:0], state_after[47:16]
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  wire logic [31:0]   prdata;
  wire logic          pready;

  dice_req_t   pending_reqs[$];
  dice_res_t   rolls_due[$];
  dice_req_t   held_req;
  logic [31:0] gen_model = SEED_FALLBACK;
  bit          idle_on = 1'b1;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned mismatches = 0;

  xorshift32_dice_generator i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] xorshift_next(input logic [31:0] x);
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // One generator step, then the top byte scaled by the limit, below it when the limit is nonzero.
  function automatic logic [7:0] scaled_roll(input logic [7:0] limit);
    logic [15:0] prod;
    gen_model = xorshift_next(gen_model);
    prod = gen_model[31:24] * limit;
    return prod[15:8];
  endfunction

  function automatic void predict_roll(input dice_req_t r);
    dice_res_t res;
    logic [7:0] total;
    res.value = '0;
    case (r.op)
      OP_WORD: begin
        gen_model = xorshift_next(gen_model);
        res.value = gen_model[31:16];
      end
      OP_BYTE: begin
        gen_model = xorshift_next(gen_model);
        res.value = {8'h00, gen_model[31:24]};
      end
      OP_RANGE: res.value = {8'h00, scaled_roll(r.bound)};
      default: begin
        total = '0;
        for (int i = 0; i < r.count; i++) total = total + 8'd1 + scaled_roll(r.bound);
        res.value = {8'h00, total};
      end
    endcase
    res.state = gen_model;
    rolls_due.push_back(res);
  endfunction

  task automatic report(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Sender: hold the item until accepted, predict on accept, then load the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_roll(held_req);
      if (!s_tvalid || s_tready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          held_req = pending_reqs.pop_front();
          s_tdata <= {6'b0, held_req.count, held_req.bound, held_req.op};
          s_tvalid <= 1'b1;
          if (idle_on && $urandom_range(0, 9) < 3) in_gap <= idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest expectation, stall at random.
  always @(posedge clk) begin
    dice_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rolls_due.size() == 0) begin
          report($sformatf("result %h with nothing expected", m_tdata));
        end else begin
          want = rolls_due.pop_front();
          if (m_tdata[15:0] !== want.value)
            report($sformatf("value %h, want %h", m_tdata[15:0], want.value));
          if (m_tdata[47:16] !== want.state)
            report($sformatf("state_after %h, want %h", m_tdata[47:16], want.state));
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= idle_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(input op_t op, input logic [7:0] bound, input logic [7:0] count);
    dice_req_t r;
    r.op = op;
    r.bound = bound;
    r.count = count;
    pending_reqs.push_back(r);
  endtask

  function automatic dice_req_t random_req();
    dice_req_t r;
    int unsigned pick;
    r.op = op_t'(2'($urandom_range(0, 3)));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.bound = 8'd0;
    else if (pick == 1) r.bound = 8'd255;
    else if (pick < 6) r.bound = 8'($urandom_range(1, 12));
    else r.bound = 8'($urandom_range(0, 255));
    if (r.op == OP_DICE) begin
      pick = $urandom_range(0, 49);
      if (pick == 0) r.count = 8'($urandom_range(100, 255));
      else if (pick < 4) r.count = 8'd0;
      else if (pick < 8) r.count = 8'($urandom_range(9, 30));
      else r.count = 8'($urandom_range(1, 8));
    end else begin
      r.count = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Wait until nothing is queued, offered or expected.
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || rolls_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SEED) gen_model = (data == 32'd0) ? SEED_FALLBACK : data;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, every operation, field extremes and corner cases.
    push_req(OP_WORD, 8'd0, 8'd0);
    push_req(OP_WORD, 8'd255, 8'd255);
    push_req(OP_BYTE, 8'd0, 8'd0);
    push_req(OP_BYTE, 8'd255, 8'd255);
    push_req(OP_RANGE, 8'd0, 8'd0);
    push_req(OP_RANGE, 8'd1, 8'd255);
    push_req(OP_RANGE, 8'd128, 8'd7);
    push_req(OP_RANGE, 8'd255, 8'd0);
    push_req(OP_DICE, 8'd6, 8'd0);
    push_req(OP_DICE, 8'd6, 8'd1);
    push_req(OP_DICE, 8'd6, 8'd3);
    push_req(OP_DICE, 8'd0, 8'd5);
    push_req(OP_DICE, 8'd1, 8'd2);
    push_req(OP_DICE, 8'd255, 8'd255);
    push_req(OP_DICE, 8'd0, 8'd255);
    push_req(OP_DICE, 8'd255, 8'd0);
    drain();
    reg_write(REG_SEED, 32'd0);
    reg_write(REG_SPARE, 32'hDEADBEEF);
    push_req(OP_WORD, 8'd3, 8'd3);
    push_req(OP_DICE, 8'd20, 8'd4);
    drain();
    reg_write(REG_SEED, 32'hFFFFFFFF);
    push_req(OP_WORD, 8'd0, 8'd0);
    push_req(OP_BYTE, 8'd0, 8'd0);
    drain();
    reg_write(REG_SEED, 32'd1);
    push_req(OP_WORD, 8'd0, 8'd0);
    push_req(OP_RANGE, 8'd255, 8'd0);
    drain();

    // Random phases, each with its own seed; one phase runs without idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: reg_write(REG_SEED, 32'h80000000);
        1: reg_write(REG_SEED, 32'd0);
        default: reg_write(REG_SEED, $urandom);
      endcase
      idle_on = (ph != 2);
      for (int n = 0; n < 200; n++) pending_reqs.push_back(random_req());
      if (ph == 3) drain();  // hold off the sender until every result is back
      for (int n = 0; n < 200; n++) pending_reqs.push_back(random_req());
      drain();
    end

    repeat (20) @(posedge clk);
    if (rolls_due.size() != 0) report($sformatf("%0d results never arrived", rolls_due.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(64'd30_000_000);
    $display("timeout, %0d results outstanding", rolls_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
sv/xsd_pkg.sv
sv/xsd_step.sv
sv/xsd_seq.sv
sv/xorshift32_dice_generator.sv
verif/tb.sv
